/* rtl/ctse_pkg.sv */
package ctse_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 21;
  localparam int IDX_W     = 4;
  localparam int NODES     = 10;
  // working width for polynomial terms; every term stays well below 2^31
  localparam int WK_W      = 32;

  localparam logic signed [WK_W-1:0] ONE = WK_W'(1) <<< FRAC_BITS;
  localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

  typedef logic signed [WK_W-1:0] wk_t;
  typedef logic signed [OUT_W-1:0] out_t;

  // Node selection for the result sequencer.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } node_t;

  // round(a*b / 2^FRAC_BITS), ties away from zero
  function automatic wk_t fx_mul(wk_t a, wk_t b);
    logic signed [2*WK_W-1:0] p;
    logic [2*WK_W-1:0] m;
    logic neg;
    p   = (2*WK_W)'(a) * (2*WK_W)'(b);
    neg = p[2*WK_W-1];
    m   = neg ? (2*WK_W)'(-p) : (2*WK_W)'(p);
    m   = (m + ((2*WK_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -WK_W'(m) : WK_W'(m);
  endfunction

  // round(v / 2^k), ties away from zero, then saturate to output range
  function automatic out_t fx_out(wk_t v, logic k3);
    logic [WK_W-1:0] m;
    logic neg;
    wk_t q;
    neg = v[WK_W-1];
    m   = neg ? WK_W'(-v) : WK_W'(v);
    if (k3) m = (m + WK_W'(4)) >> 3;
    else    m = (m + WK_W'(8)) >> 4;
    q = neg ? -wk_t'(m) : wk_t'(m);
    if (q > wk_t'((1 <<< (OUT_W-1)) - 1)) return out_t'((1 <<< (OUT_W-1)) - 1);
    if (q < -wk_t'(1 <<< (OUT_W-1)))     return out_t'(-(1 <<< (OUT_W-1)));
    return out_t'(q);
  endfunction

endpackage

/* rtl/ctse_core.sv */
// Three-stage arithmetic pipeline: squares, first factor pairs, second products and scaling.
module ctse_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [ctse_pkg::IN_W-1:0] r_i,
  input  logic signed [ctse_pkg::IN_W-1:0] s_i,
  output logic                           valid_o,
  output ctse_pkg::out_t                 nv_o [ctse_pkg::NODES],
  output ctse_pkg::out_t                 dr_o [ctse_pkg::NODES],
  output ctse_pkg::out_t                 ds_o [ctse_pkg::NODES]
);
  import ctse_pkg::*;

  logic [2:0] v_q;
  wk_t r1_q, s1_q, rr_q, ss_q, rs_q, uu_q;
  wk_t pu_q, pa_q, pb_q, pab_q, paa_q, pbb_q, pau_q, pbu_q;
  wk_t r2_q, s2_q, rr2_q, ss2_q, rs2_q, uu2_q;
  wk_t m0_q, m1_q, m2_q, m3_q, m4_q, m6_q, m7_q, m8_q, m9_q;
  wk_t e5_q, e6_q, e8_q, e9_q, f3_q, f4_q, f6_q, f9_q;
  wk_t r_w, s_w, u1, a1, b1, u2, a2, b2;
  out_t n9_q;

  assign r_w = WK_W'(r_i);
  assign s_w = WK_W'(s_i);
  assign u1 = r1_q + s1_q;
  assign a1 = ONE + r1_q;
  assign b1 = ONE + s1_q;
  assign u2 = r2_q + s2_q;
  assign a2 = ONE + r2_q;
  assign b2 = ONE + s2_q;

  // valid shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end
  assign valid_o = v_q[2];

  // stage 1: squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r_w;
      s1_q <= s_w;
      rr_q <= fx_mul(r_w, r_w);
      ss_q <= fx_mul(s_w, s_w);
      rs_q <= fx_mul(r_w, s_w);
      uu_q <= fx_mul(r_w + s_w, r_w + s_w);
    end
  end

  // stage 2: first factor pairs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q <= r1_q; s2_q <= s1_q;
      rr2_q <= rr_q; ss2_q <= ss_q; rs2_q <= rs_q; uu2_q <= uu_q;
      pu_q  <= fx_mul(u1, 2*ONE + 3*u1);
      pa_q  <= fx_mul(a1, ONE - 3*r1_q);
      pb_q  <= fx_mul(b1, ONE - 3*s1_q);
      pau_q <= fx_mul(a1, u1);
      paa_q <= fx_mul(a1, ONE + 3*r1_q);
      pab_q <= fx_mul(a1, b1);
      pbb_q <= fx_mul(b1, ONE + 3*s1_q);
      pbu_q <= fx_mul(b1, u1);
      e5_q <= fx_mul(2*ONE + 3*r1_q, b1);
      e8_q <= fx_mul(b1, ONE + 3*u1);
      e9_q <= fx_mul(b1, ONE + 2*r1_q + s1_q);
      f3_q <= fx_mul(a1, ONE + 3*u1);
      f6_q <= fx_mul(a1, 2*ONE + 3*s1_q);
      f9_q <= fx_mul(a1, ONE + r1_q + 2*s1_q);
      e6_q <= fx_mul(b1, ONE + 3*s1_q);
      f4_q <= fx_mul(a1, ONE + 3*r1_q);
    end
  end

  // stage 3: second products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= fx_mul(pu_q, 4*ONE + 3*u2);
      m1_q <= fx_mul(pa_q, ONE + 3*r2_q);
      m2_q <= fx_mul(pb_q, ONE + 3*s2_q);
      m3_q <= fx_mul(pau_q, 3*u2 + 2*ONE);
      m4_q <= fx_mul(paa_q, u2);
      m6_q <= fx_mul(paa_q, b2);
      m7_q <= fx_mul(pab_q, ONE + 3*s2_q);
      m8_q <= fx_mul(pbb_q, u2);
      m9_q <= fx_mul(pbu_q, 3*u2 + 2*ONE);
      n9_q <= fx_out(-27 * fx_mul(pab_q, u2), 1'b1);
      dr_o[0] <= fx_out(-(8*ONE + 36*u2 + 27*uu2_q), 1'b0);
      ds_o[0] <= fx_out(-(8*ONE + 36*u2 + 27*uu2_q), 1'b0);
      dr_o[1] <= fx_out(-(ONE - 18*r2_q - 27*rr2_q), 1'b0);
      dr_o[2] <= '0;
      dr_o[3] <= fx_out(9 * (2*ONE + 10*r2_q + 8*s2_q + 9*rr2_q + 12*rs2_q + 3*ss2_q), 1'b0);
      dr_o[4] <= fx_out(-9 * (ONE + 8*r2_q + 4*s2_q + 9*rr2_q + 6*rs2_q), 1'b0);
      dr_o[5] <= fx_out(9 * e5_q, 1'b1);
      dr_o[6] <= fx_out(9 * e6_q, 1'b0);
      dr_o[7] <= fx_out(-9 * e6_q, 1'b0);
      dr_o[8] <= fx_out(9 * e8_q, 1'b1);
      dr_o[9] <= fx_out(-27 * e9_q, 1'b1);
      ds_o[1] <= '0;
      ds_o[2] <= fx_out(27*ss2_q + 18*s2_q - ONE, 1'b0);
      ds_o[3] <= fx_out(9 * f3_q, 1'b1);
      ds_o[4] <= fx_out(-9 * f4_q, 1'b0);
      ds_o[5] <= fx_out(9 * f4_q, 1'b0);
      ds_o[6] <= fx_out(9 * f6_q, 1'b1);
      ds_o[7] <= fx_out(-9 * (ONE + 4*r2_q + 8*s2_q + 6*rs2_q + 9*ss2_q), 1'b0);
      ds_o[8] <= fx_out(9 * (2*ONE + 8*r2_q + 10*s2_q + 3*rr2_q + 12*rs2_q + 9*ss2_q), 1'b0);
      ds_o[9] <= fx_out(-27 * f9_q, 1'b1);
    end
  end

  // final node value scaling
  always_comb begin
    nv_o[0] = fx_out(-m0_q, 1'b0);
    nv_o[1] = fx_out(-m1_q, 1'b0);
    nv_o[2] = fx_out(-m2_q, 1'b0);
    nv_o[3] = fx_out(9 * m3_q, 1'b0);
    nv_o[4] = fx_out(-9 * m4_q, 1'b0);
    nv_o[5] = fx_out(9 * m6_q, 1'b0);
    nv_o[6] = fx_out(9 * m7_q, 1'b0);
    nv_o[7] = fx_out(-9 * m8_q, 1'b0);
    nv_o[8] = fx_out(9 * m9_q, 1'b0);
    nv_o[9] = n9_q;
  end

endmodule

/* rtl/ctse_ser.sv */
// Holds one point's ten results and sends them one per cycle while ready_i is high.
module ctse_ser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ctse_pkg::out_t nv_i [ctse_pkg::NODES],
  input  ctse_pkg::out_t dr_i [ctse_pkg::NODES],
  input  ctse_pkg::out_t ds_i [ctse_pkg::NODES],
  output logic           busy_o,
  output logic           free_o,
  output logic           valid_o,
  input  logic           ready_i,
  output ctse_pkg::node_t node_o,
  output ctse_pkg::out_t shape_o,
  output ctse_pkg::out_t dr_o,
  output ctse_pkg::out_t ds_o
);
  import ctse_pkg::*;

  out_t nv_q [NODES];
  out_t dr_q [NODES];
  out_t ds_q [NODES];
  logic busy_q;
  logic [IDX_W-1:0] idx_q;
  logic done;

  assign done   = busy_q && ready_i && (idx_q == LAST_NODE);
  assign busy_o = busy_q;
  assign free_o = !busy_q || done;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && ready_i) begin
      busy_q <= idx_q != LAST_NODE;
      idx_q  <= idx_q + IDX_W'(1);
    end
  end

  // result buffer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      nv_q <= nv_i;
      dr_q <= dr_i;
      ds_q <= ds_i;
    end
  end

  assign valid_o     = busy_q;
  assign node_o.idx  = idx_q;
  assign node_o.last = idx_q == LAST_NODE;
  assign shape_o     = nv_q[idx_q];
  assign dr_o        = dr_q[idx_q];
  assign ds_o        = ds_q[idx_q];

endmodule

/* rtl/cubic_triangle_shape_eval_top.sv */
// Cubic 10-node triangle shape function evaluator.
// Input channel: one point (r_coord_i, s_coord_i), signed Q1.16, taken on
// in_valid_i && in_ready_o.
// Output channel: ten transactions per point, node 0 to 9 in order, each
// with shape value and r/s derivatives in signed Q4.16, saturated;
// last_o marks node 9. Taken on out_valid_o && out_ready_i.
// Path: a taken point passes the three arithmetic stages, then is loaded into the
// sequencer's result buffer, which raises out_valid_o for node 0.
// Throughput: one result per cycle while out_ready_i is high; a point's ten
// results drain through the single output port. Up to three further points sit
// in the three-stage arithmetic pipeline while results drain.
// Reset: clears all valid bits and the sequencer; no results pending.
// Stall: when out_ready_i is low the sequencer holds its node; the
// pipeline stops advancing once its last stage holds a finished point, so
// no point is dropped or repeated.
module cubic_triangle_shape_eval_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ctse_pkg::IN_W-1:0]   r_coord_i,
  input  logic signed [ctse_pkg::IN_W-1:0]   s_coord_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ctse_pkg::IDX_W-1:0]         node_index_o,
  output logic signed [ctse_pkg::OUT_W-1:0]  shape_value_o,
  output logic signed [ctse_pkg::OUT_W-1:0]  slope_r_o,
  output logic signed [ctse_pkg::OUT_W-1:0]  slope_s_o,
  output logic                               last_o
);
  import ctse_pkg::*;

  logic en, pv, busy, free, load;
  out_t nv [NODES];
  out_t dr [NODES];
  out_t ds [NODES];
  node_t node;

  // pipeline advances unless a finished point waits on the sequencer
  assign en         = !pv || free;
  assign load       = pv && free;
  assign in_ready_o = en;

  ctse_core u_core (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .r_i(r_coord_i), .s_i(s_coord_i),
    .valid_o(pv), .nv_o(nv), .dr_o(dr), .ds_o(ds)
  );

  ctse_ser u_ser (
    .clk_i, .rst_ni, .load_i(load), .nv_i(nv), .dr_i(dr), .ds_i(ds),
    .busy_o(busy), .free_o(free), .valid_o(out_valid_o), .ready_i(out_ready_i),
    .node_o(node), .shape_o(shape_value_o), .dr_o(slope_r_o), .ds_o(slope_s_o)
  );

  assign node_index_o = busy ? node.idx : node.idx;
  assign last_o       = node.last;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ctse_pkg::*;

  typedef logic signed [IN_W-1:0] coord_t;

  // one expected node transaction
  typedef struct {
    logic [IDX_W-1:0] idx;
    out_t             nval;
    out_t             dr;
    out_t             ds;
    logic             last;
  } node_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  coord_t           r_coord_i = '0;
  coord_t           s_coord_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [IDX_W-1:0] node_index_o;
  out_t             shape_value_o;
  out_t             slope_r_o;
  out_t             slope_s_o;
  logic             last_o;

  node_res_t node_q[$];
  int        n_errors = 0;
  int        n_points = 0;
  int        n_nodes = 0;
  bit        tx_idle = 1'b0;
  bit        rx_idle = 1'b0;
  int        rx_wait = 0;
  int        rx_hold = 0;
  event      hold_ev;

  cubic_triangle_shape_eval_top uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  // product of two fixed values, rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = ((p < 0 ? -p : p) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return p < 0 ? -m : m;
  endfunction

  // scale down by 2^k with rounding, then clamp to output range
  function automatic out_t qout(longint v, int k);
    longint m;
    m = ((v < 0 ? -v : v) + (64'sd1 <<< (k - 1))) >>> k;
    m = v < 0 ? -m : m;
    if (m > 1048575) m = 1048575;
    if (m < -1048576) m = -1048576;
    return out_t'(m);
  endfunction

  // ten node shape values and gradients at (r, s)
  task automatic predict_nodes(coord_t rc, coord_t sc);
    longint one, r, s, u, a, b, a3, b3, rr, ss, rs, uu, c2;
    out_t nv[NODES], gr[NODES], gs[NODES];
    out_t d0;
    node_res_t e;
    one = 64'sd1 <<< FRAC_BITS;
    r = rc;
    s = sc;
    u = r + s;
    a = one + r;
    b = one + s;
    a3 = one + 3 * r;
    b3 = one + 3 * s;
    rr = qmul(r, r);
    ss = qmul(s, s);
    rs = qmul(r, s);
    uu = qmul(u, u);
    c2 = 3 * u + 2 * one;

    nv[0] = qout(-qmul(qmul(u, 2 * one + 3 * u), 4 * one + 3 * u), 4);
    nv[1] = qout(-qmul(qmul(a, one - 3 * r), a3), 4);
    nv[2] = qout(-qmul(qmul(b, one - 3 * s), b3), 4);
    nv[3] = qout(9 * qmul(qmul(a, u), c2), 4);
    nv[4] = qout(-9 * qmul(qmul(a, a3), u), 4);
    nv[5] = qout(9 * qmul(qmul(a, a3), b), 4);
    nv[6] = qout(9 * qmul(qmul(a, b), b3), 4);
    nv[7] = qout(-9 * qmul(qmul(b, b3), u), 4);
    nv[8] = qout(9 * qmul(qmul(b, u), c2), 4);
    nv[9] = qout(-27 * qmul(qmul(a, b), u), 3);

    d0 = qout(-(8 * one + 36 * u + 27 * uu), 4);

    // d/dr
    gr[0] = d0;
    gr[1] = qout(-(one - 18 * r - 27 * rr), 4);
    gr[2] = '0;
    gr[3] = qout(9 * (2 * one + 10 * r + 8 * s + 9 * rr + 12 * rs + 3 * ss), 4);
    gr[4] = qout(-9 * (one + 8 * r + 4 * s + 9 * rr + 6 * rs), 4);
    gr[5] = qout(9 * qmul(2 * one + 3 * r, b), 3);
    gr[6] = qout(9 * qmul(b, b3), 4);
    gr[7] = qout(-9 * qmul(b, b3), 4);
    gr[8] = qout(9 * qmul(b, one + 3 * u), 3);
    gr[9] = qout(-27 * qmul(b, one + 2 * r + s), 3);

    // d/ds
    gs[0] = d0;
    gs[1] = '0;
    gs[2] = qout(27 * ss + 18 * s - one, 4);
    gs[3] = qout(9 * qmul(a, one + 3 * u), 3);
    gs[4] = qout(-9 * qmul(a, a3), 4);
    gs[5] = qout(9 * qmul(a, a3), 4);
    gs[6] = qout(9 * qmul(a, 2 * one + 3 * s), 3);
    gs[7] = qout(-9 * (one + 4 * r + 8 * s + 6 * rs + 9 * ss), 4);
    gs[8] = qout(9 * (2 * one + 8 * r + 10 * s + 3 * rr + 12 * rs + 9 * ss), 4);
    gs[9] = qout(-27 * qmul(a, one + r + 2 * s), 3);

    for (int k = 0; k < NODES; k++) begin
      e.idx = IDX_W'(k);
      e.nval = nv[k];
      e.dr = gr[k];
      e.ds = gs[k];
      e.last = (k == NODES - 1);
      node_q.push_back(e);
    end
  endtask

  // offer one point, return on the edge where it is taken
  task automatic send_point(coord_t rc, coord_t sc);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    r_coord_i <= rc;
    s_coord_i <= sc;
    do @(posedge clk_i); while (!in_ready_o);
    predict_nodes(rc, sc);
    n_points++;
  endtask

  // receiver: stall control and result check
  always @(posedge clk_i) begin
    node_res_t e;
    if (out_valid_o && out_ready_i) begin
      n_nodes++;
      if (node_q.size() == 0) begin
        $error("unexpected transaction, node_index %0d", node_index_o);
        n_errors++;
      end else begin
        e = node_q.pop_front();
        if (node_index_o !== e.idx) begin
          $error("node_index: expected %0d, actual %0d", e.idx, node_index_o);
          n_errors++;
        end
        if (shape_value_o !== e.nval) begin
          $error("shape_value: expected %0d, actual %0d", e.nval, shape_value_o);
          n_errors++;
        end
        if (slope_r_o !== e.dr) begin
          $error("slope_r: expected %0d, actual %0d", e.dr, slope_r_o);
          n_errors++;
        end
        if (slope_s_o !== e.ds) begin
          $error("slope_s: expected %0d, actual %0d", e.ds, slope_s_o);
          n_errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0b, actual %0b", e.last, last_o);
          n_errors++;
        end
      end
      if (rx_idle) rx_wait = $urandom_range(0, 19);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_ready_i <= (rx_wait == 0 && rx_hold == 0);
  end

  // long receiver hold, counted down one cycle at a time
  initial begin
    forever begin
      @(hold_ev);
      rx_hold = 300;
      while (rx_hold > 0) begin
        @(posedge clk_i);
        rx_hold--;
      end
    end
  end

  // drop valid and let all pending nodes drain
  task automatic drain;
    in_valid_i <= 1'b0;
    while (node_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // vertices, centroid, field extremes, edges
  task automatic test_directed;
    int pts[17][2];
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    pts = '{'{-65536, -65536}, '{65536, -65536}, '{-65536, 65536}, '{0, 0},
            '{-21845, -21845}, '{65536, 65536}, '{-131072, -131072},
            '{131071, 131071}, '{-131072, 131071}, '{131071, -131072},
            '{0, -65536}, '{-65536, 0}, '{1, -1}, '{-1, 1}, '{21845, -43691},
            '{43690, 43690}, '{-65535, 65535}};
    foreach (pts[i]) send_point(coord_t'(pts[i][0]), coord_t'(pts[i][1]));
    drain();
  endtask

  // random points, mostly inside -1..1, some over the whole field
  task automatic test_random(int count, bit tx_gaps, bit rx_gaps);
    coord_t rc, sc;
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        rc = coord_t'($urandom);
        sc = coord_t'($urandom);
      end else begin
        rc = coord_t'(int'($urandom_range(0, 131072)) - 65536);
        sc = coord_t'(int'($urandom_range(0, 131072)) - 65536);
      end
      send_point(rc, sc);
    end
    drain();
  endtask

  // receiver holds off long enough that the input stalls
  task automatic test_backpressure;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    -> hold_ev;
    test_random(20, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100, 1'b0, 1'b0);
    test_random(100, 1'b1, 1'b1);
    test_backpressure();
    test_random(90, 1'b1, 1'b0);
    test_random(90, 1'b0, 1'b1);
    $display("covered %0d points, %0d node results, with random gaps and a long output stall",
             n_points, n_nodes);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* cubic_triangle_shape_eval_top.f */
rtl/ctse_pkg.sv
rtl/ctse_core.sv
rtl/ctse_ser.sv
rtl/cubic_triangle_shape_eval_top.sv
test/testbench.sv
